/* rtl/core/tmcw_pkg.sv */
`default_nettype none
package tmcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int CELL_W         = $clog2(CELL_COUNT);

  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  localparam int MOUSE_HOME_COL = (40 > SCREEN_COLUMNS - 1) ? SCREEN_COLUMNS - 1 : 40;
  localparam int MOUSE_HOME_ROW = (12 > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : 12;
  localparam int MOUSE_HOME_IDX = MOUSE_HOME_ROW * SCREEN_COLUMNS + MOUSE_HOME_COL;

  localparam logic [1:0] OP_PUT_CHAR  = 2'd0;
  localparam logic [1:0] OP_PUT_HEX   = 2'd1;
  localparam logic [1:0] OP_MOUSE     = 2'd2;
  localparam logic [1:0] OP_READ_CELL = 2'd3;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] BLANK_ATTR   = 8'h07;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         char_code;
    logic signed [7:0]  move_dx;
    logic signed [7:0]  move_dy;
    logic [10:0]        cell_index;
  } tmcw_in_t;

  typedef struct packed {
    logic [COL_W-1:0] text_column;
    logic [ROW_W-1:0] text_line;
    logic [COL_W-1:0] pointer_column;
    logic [ROW_W-1:0] pointer_line;
    logic [15:0]      cell_word;
    logic             screen_blanked;
  } tmcw_out_t;

  // write and read controls for the attribute and character arrays
  typedef struct packed {
    logic              attr_we;
    logic              char_we;
    logic [CELL_W-1:0] wr_addr;
    logic [7:0]        attr_wdata;
    logic [7:0]        char_wdata;
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
  } tmcw_mem_req_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + n) : (8'h37 + n);
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return CELL_W'(row) * CELL_W'(SCREEN_COLUMNS) + CELL_W'(col);
  endfunction

  function automatic logic [7:0] swap_attr(input logic [7:0] a);
    return {a[3:0], a[7:4]};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tmcw_cell_store.sv */
`default_nettype none
module tmcw_cell_store (
  input  wire logic                   clk,
  input  wire tmcw_pkg::tmcw_mem_req_t req,
  output logic [7:0]                  attr_q,
  output logic [7:0]                  char_q
);
  import tmcw_pkg::*;

  logic [7:0] attr_mem [CELL_COUNT];
  logic [7:0] char_mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.attr_we) begin
      attr_mem[req.wr_addr] <= req.attr_wdata;
    end
    if (req.rd_en) begin
      attr_q <= attr_mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.char_we) begin
      char_mem[req.wr_addr] <= req.char_wdata;
    end
    if (req.rd_en) begin
      char_q <= char_mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/text_mode_console_writer.sv */
`default_nettype none
// Text console with an 80x25 cell store, a text cursor and a mouse cursor. A command is
// taken when start is high and busy is low; its result appears on result for one cycle
// with done high and cannot be held off. After reset the block is busy while it fills every
// cell, one cell a cycle. A mouse move does a read-modify-write of the attribute at the old
// and then the new cell. A command that runs the text cursor past the last row adds a sweep
// that rewrites every character to a space, one cell a cycle through the write port.
module text_mode_console_writer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire tmcw_pkg::tmcw_in_t  cmd,
  output logic                     busy,
  output logic                     done,
  output tmcw_pkg::tmcw_out_t      result
);
  import tmcw_pkg::*;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_PUT      = 4'd2;
  localparam logic [3:0] ST_PUT2     = 4'd3;
  localparam logic [3:0] ST_BLANK    = 4'd4;
  localparam logic [3:0] ST_WR_OLD   = 4'd5;
  localparam logic [3:0] ST_RD_NEW   = 4'd6;
  localparam logic [3:0] ST_WR_NEW   = 4'd7;
  localparam logic [3:0] ST_RD_CELL  = 4'd8;

  logic [3:0]        state;
  logic [CELL_W-1:0] clr_cnt;
  tmcw_in_t          cmd_q;
  logic              in_range_q;
  logic              second;
  logic [COL_W-1:0]  text_col;
  logic [ROW_W-1:0]  text_row;
  logic [COL_W-1:0]  mouse_col;
  logic [ROW_W-1:0]  mouse_row;
  logic [15:0]       word_q;
  logic              blanked_q;

  tmcw_mem_req_t     mem_req;
  logic [7:0]        attr_q;
  logic [7:0]        char_q;

  logic              accept;
  logic              cell_in_range;
  logic [CELL_W-1:0] text_idx;
  logic [CELL_W-1:0] mouse_idx;
  logic              clr_last;

  logic [7:0]        put_ch;
  logic [COL_W:0]    col_t;
  logic [ROW_W:0]    row_t;
  logic              put_wr;
  logic              put_ovf;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;

  logic signed [8:0] mcol_sum;
  logic signed [8:0] mrow_sum;
  logic [COL_W-1:0]  mouse_col_next;
  logic [ROW_W-1:0]  mouse_row_next;

  tmcw_cell_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .attr_q (attr_q),
    .char_q (char_q)
  );

  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign cell_in_range = (cmd.cell_index < CELL_W'(CELL_COUNT));
  assign text_idx      = cell_addr(text_row, text_col);
  assign mouse_idx     = cell_addr(mouse_row, mouse_col);
  assign clr_last      = (clr_cnt == CELL_W'(CELL_COUNT - 1));

  // one byte at the text cursor: newline, wrap and overflow
  always_comb begin
    if (state == ST_PUT2) begin
      put_ch = hex_char(cmd_q.char_code[3:0]);
    end else if (cmd_q.opcode == OP_PUT_HEX) begin
      put_ch = hex_char(cmd_q.char_code[7:4]);
    end else begin
      put_ch = cmd_q.char_code;
    end
    if (put_ch == NEWLINE_CHAR) begin
      put_wr = 1'b0;
      col_t  = '0;
      row_t  = {1'b0, text_row} + 1'b1;
    end else begin
      put_wr = 1'b1;
      col_t  = {1'b0, text_col} + 1'b1;
      row_t  = {1'b0, text_row};
    end
    if (col_t >= (COL_W+1)'(SCREEN_COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    put_ovf = (row_t >= (ROW_W+1)'(SCREEN_ROWS));
    put_col = put_ovf ? '0 : col_t[COL_W-1:0];
    put_row = put_ovf ? '0 : row_t[ROW_W-1:0];
  end

  // mouse move clamps at full precision
  always_comb begin
    mcol_sum = $signed({2'b00, mouse_col}) + 9'(cmd_q.move_dx);
    mrow_sum = $signed({4'b0000, mouse_row}) + 9'(cmd_q.move_dy);
    if (mcol_sum < 0) begin
      mouse_col_next = '0;
    end else if (mcol_sum > 9'(SCREEN_COLUMNS - 1)) begin
      mouse_col_next = COL_W'(SCREEN_COLUMNS - 1);
    end else begin
      mouse_col_next = mcol_sum[COL_W-1:0];
    end
    if (mrow_sum < 0) begin
      mouse_row_next = '0;
    end else if (mrow_sum > 9'(SCREEN_ROWS - 1)) begin
      mouse_row_next = ROW_W'(SCREEN_ROWS - 1);
    end else begin
      mouse_row_next = mrow_sum[ROW_W-1:0];
    end
  end

  always_comb begin
    mem_req = '0;
    case (state)
      ST_INIT: begin
        mem_req.attr_we    = 1'b1;
        mem_req.char_we    = 1'b1;
        mem_req.wr_addr    = clr_cnt;
        mem_req.attr_wdata = (clr_cnt == CELL_W'(MOUSE_HOME_IDX)) ? swap_attr(BLANK_ATTR)
                                                                 : BLANK_ATTR;
        mem_req.char_wdata = SPACE_CHAR;
      end
      ST_IDLE: begin
        if (accept && cmd.opcode == OP_MOUSE) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = mouse_idx;
        end else if (accept && cmd.opcode == OP_READ_CELL && cell_in_range) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cmd.cell_index[CELL_W-1:0];
        end
      end
      ST_PUT, ST_PUT2: begin
        mem_req.char_we    = put_wr;
        mem_req.wr_addr    = text_idx;
        mem_req.char_wdata = put_ch;
      end
      ST_BLANK: begin
        mem_req.char_we    = 1'b1;
        mem_req.wr_addr    = clr_cnt;
        mem_req.char_wdata = SPACE_CHAR;
      end
      ST_WR_OLD, ST_WR_NEW: begin
        mem_req.attr_we    = 1'b1;
        mem_req.wr_addr    = mouse_idx;
        mem_req.attr_wdata = swap_attr(attr_q);
      end
      ST_RD_NEW: begin
        // the old cell was written back in the cycle before, so no overlap
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = mouse_idx;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_cnt   <= '0;
      second    <= 1'b0;
      text_col  <= '0;
      text_row  <= '0;
      mouse_col <= COL_W'(MOUSE_HOME_COL);
      mouse_row <= ROW_W'(MOUSE_HOME_ROW);
      done      <= 1'b0;
      blanked_q <= 1'b0;
      word_q    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_INIT: begin
          clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
          if (clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd;
            in_range_q <= cell_in_range;
            second     <= 1'b0;
            blanked_q  <= 1'b0;
            word_q     <= '0;
            case (cmd.opcode)
              OP_PUT_CHAR, OP_PUT_HEX: state <= ST_PUT;
              OP_MOUSE:                state <= ST_WR_OLD;
              default:                 state <= ST_RD_CELL;
            endcase
          end
        end
        ST_PUT, ST_PUT2: begin
          text_col <= put_col;
          text_row <= put_row;
          second   <= (state == ST_PUT2);
          if (put_ovf) begin
            state <= ST_BLANK;
          end else if (state == ST_PUT && cmd_q.opcode == OP_PUT_HEX) begin
            state <= ST_PUT2;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_BLANK: begin
          blanked_q <= 1'b1;
          clr_cnt   <= clr_last ? '0 : clr_cnt + 1'b1;
          if (clr_last) begin
            if (cmd_q.opcode == OP_PUT_HEX && !second) begin
              state <= ST_PUT2;
            end else begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end
          end
        end
        ST_WR_OLD: begin
          mouse_col <= mouse_col_next;
          mouse_row <= mouse_row_next;
          state     <= ST_RD_NEW;
        end
        ST_RD_NEW: begin
          state <= ST_WR_NEW;
        end
        ST_WR_NEW: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_RD_CELL: begin
          if (in_range_q) begin
            word_q <= {attr_q, char_q};
          end
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.text_column    = text_col;
  assign result.text_line      = text_row;
  assign result.pointer_column = mouse_col;
  assign result.pointer_line   = mouse_row;
  assign result.cell_word      = word_q;
  assign result.screen_blanked = blanked_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while the sequencer is still busy");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(mem_req.attr_we || mem_req.char_we))
    else $error("cell store written with no command in progress");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (text_col < COL_W'(SCREEN_COLUMNS)) && (text_row < ROW_W'(SCREEN_ROWS)) &&
    (mouse_col < COL_W'(SCREEN_COLUMNS)) && (mouse_row < ROW_W'(SCREEN_ROWS)))
    else $error("cursor outside the screen");

  a_blank_no_word: assert property (@(posedge clk) disable iff (rst)
    (done && result.screen_blanked) |-> (result.cell_word == '0))
    else $error("blanking step returned a cell word");

  a_mouse_rmw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_NEW) |-> ($past(state) == ST_RD_NEW))
    else $error("mouse write-back without its read");
`endif

endmodule
`default_nettype wire

/* tb/console_checker.sv */
module console_checker
  import tmcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire tmcw_in_t  cmd,
  input  wire logic      done,
  input  wire tmcw_out_t result,
  output int             fail_count,
  output int             pending
);

  logic [15:0] cells [CELL_COUNT];
  int          cur_col;
  int          cur_row;
  int          ptr_col;
  int          ptr_row;
  int          results_seen;
  tmcw_out_t   status_fifo [$];

  function automatic logic [15:0] nibble_swap(input logic [15:0] w);
    return {w[11:8], w[15:12], w[7:0]};
  endfunction

  function automatic void flip_pointer_cell();
    int idx;
    idx = ptr_row * SCREEN_COLUMNS + ptr_col;
    cells[idx] = nibble_swap(cells[idx]);
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v > hi) return hi;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    return (nib > 4'd9) ? 8'h41 + {4'h0, nib} - 8'd10 : 8'h30 + {4'h0, nib};
  endfunction

  // writes one byte at the text cursor, returns 1 when the screen got blanked
  function automatic bit emit_byte(input logic [7:0] ch);
    int idx;
    int i;
    if (ch == NEWLINE_CHAR) begin
      cur_row++;
      cur_col = 0;
    end else begin
      idx = cur_row * SCREEN_COLUMNS + cur_col;
      cells[idx] = {cells[idx][15:8], ch};
      cur_col++;
    end
    if (cur_col >= SCREEN_COLUMNS) begin
      cur_row++;
      cur_col = 0;
    end
    if (cur_row >= SCREEN_ROWS) begin
      // attributes stay, characters become spaces
      for (i = 0; i < CELL_COUNT; i++)
        cells[i] = {cells[i][15:8], SPACE_CHAR};
      cur_col = 0;
      cur_row = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic tmcw_out_t console_step(input tmcw_in_t c);
    tmcw_out_t s;
    bit        blank;
    int        dx;
    int        dy;
    s     = '0;
    blank = 1'b0;
    case (c.opcode)
      OP_PUT_CHAR: blank = emit_byte(c.char_code);
      OP_PUT_HEX: begin
        if (emit_byte(hex_glyph(c.char_code[7:4]))) blank = 1'b1;
        if (emit_byte(hex_glyph(c.char_code[3:0]))) blank = 1'b1;
      end
      OP_MOUSE: begin
        dx = int'(c.move_dx);
        dy = int'(c.move_dy);
        flip_pointer_cell();
        ptr_col = clamp_to(ptr_col + dx, SCREEN_COLUMNS - 1);
        ptr_row = clamp_to(ptr_row + dy, SCREEN_ROWS - 1);
        flip_pointer_cell();
      end
      OP_READ_CELL: begin
        if (c.cell_index < 11'(CELL_COUNT)) s.cell_word = cells[c.cell_index];
      end
      default: ;
    endcase
    s.text_column    = cur_col[COL_W-1:0];
    s.text_line      = cur_row[ROW_W-1:0];
    s.pointer_column = ptr_col[COL_W-1:0];
    s.pointer_line   = ptr_row[ROW_W-1:0];
    s.screen_blanked = blank;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tmcw_out_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < CELL_COUNT; i++)
        cells[i] = {BLANK_ATTR, SPACE_CHAR};
      cur_col = 0;
      cur_row = 0;
      ptr_col = MOUSE_HOME_COL;
      ptr_row = MOUSE_HOME_ROW;
      flip_pointer_cell();
      status_fifo.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // the older beat retires before a new one is taken in
      if (done) begin
        results_seen++;
        if (status_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with nothing outstanding: %0h",
                     results_seen, result);
        end else begin
          want = status_fifo.pop_front();
          check_field("text_column", 16'(want.text_column), 16'(result.text_column));
          check_field("text_line", 16'(want.text_line), 16'(result.text_line));
          check_field("pointer_column", 16'(want.pointer_column),
                      16'(result.pointer_column));
          check_field("pointer_line", 16'(want.pointer_line), 16'(result.pointer_line));
          check_field("cell_word", want.cell_word, result.cell_word);
          check_field("screen_blanked", 16'(want.screen_blanked),
                      16'(result.screen_blanked));
        end
      end
      if (start && !busy) status_fifo.push_back(console_step(cmd));
    end
    pending <= status_fifo.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import tmcw_pkg::*;

  localparam int ITEM_TARGET  = 1050;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  tmcw_in_t  cmd;
  tmcw_out_t result;
  int        fail_count;
  int        pending;

  int               sent;
  int               burst_left;
  int               clears;
  int               op_count [4];
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_line;

  text_mode_console_writer u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  console_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
    $display("FAIL text_mode_console_writer");
    $finish;
  end

  // cursor position as last reported, used to steer runs toward the bottom edge
  always @(posedge clk) begin
    if (rst) begin
      last_col  <= '0;
      last_line <= '0;
      clears    <= 0;
    end else if (done) begin
      last_col  <= result.text_column;
      last_line <= result.text_line;
      if (result.screen_blanked) clears <= clears + 1;
    end
  end

  function automatic tmcw_in_t mk(input logic [1:0] op, input int ch, input int dx,
                                  input int dy, input int idx);
    tmcw_in_t c;
    c.opcode     = op;
    c.char_code  = ch[7:0];
    c.move_dx    = dx[7:0];
    c.move_dy    = dy[7:0];
    c.cell_index = idx[10:0];
    return c;
  endfunction

  function automatic tmcw_in_t random_cmd();
    tmcw_in_t c;
    int       pick;
    c.char_code  = 8'($urandom_range(0, 255));
    c.move_dx    = 8'($urandom_range(0, 255));
    c.move_dy    = 8'($urandom_range(0, 255));
    c.cell_index = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.opcode = OP_PUT_CHAR;
      if ($urandom_range(0, 9) == 0) c.char_code = NEWLINE_CHAR;
    end else if (pick < 55) begin
      c.opcode = OP_PUT_HEX;
    end else if (pick < 75) begin
      c.opcode = OP_MOUSE;
      // mostly short hops so the pointer wanders the interior
      if ($urandom_range(0, 3) != 0) begin
        c.move_dx = 8'($urandom_range(0, 8) - 4);
        c.move_dy = 8'($urandom_range(0, 8) - 4);
      end
    end else begin
      c.opcode = OP_READ_CELL;
      if ($urandom_range(0, 1) == 0)
        c.cell_index = 11'($urandom_range(0, 4 * SCREEN_COLUMNS));
    end
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send(input tmcw_in_t c);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    start <= 1'b1;
    cmd   <= c;
    do begin
      took = !busy;
      @(negedge clk);
    end while (!took);
    burst_left--;
    sent++;
    op_count[c.opcode]++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // newlines down to the last row, plain characters up to target_col, then a hex pair
  task automatic run_to_bottom(input int target_col);
    int       row;
    int       col;
    tmcw_in_t c;
    wait_idle();
    row = int'(last_line);
    col = int'(last_col);
    while (row < SCREEN_ROWS - 1) begin
      c = random_cmd();
      c.opcode    = OP_PUT_CHAR;
      c.char_code = NEWLINE_CHAR;
      send(c);
      row++;
      col = 0;
    end
    while (col < target_col) begin
      c = random_cmd();
      c.opcode = OP_PUT_CHAR;
      if (c.char_code == NEWLINE_CHAR) c.char_code = SPACE_CHAR;
      send(c);
      col++;
    end
    c = random_cmd();
    c.opcode = OP_PUT_HEX;
    send(c);
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    sent       = 0;
    burst_left = 0;
    foreach (op_count[i]) op_count[i] = 0;
    @(negedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(mk(OP_READ_CELL, 0, 0, 0, MOUSE_HOME_IDX));
    send(mk(OP_READ_CELL, 0, 0, 0, 0));
    send(mk(OP_PUT_CHAR, 'h00, 0, 0, 0));
    send(mk(OP_PUT_CHAR, 'hFF, 0, 0, 0));
    send(mk(OP_PUT_CHAR, 'h41, 0, 0, 0));
    send(mk(OP_READ_CELL, 0, 0, 0, 0));
    send(mk(OP_READ_CELL, 0, 0, 0, 1));
    send(mk(OP_PUT_CHAR, int'(NEWLINE_CHAR), 0, 0, 0));
    send(mk(OP_PUT_HEX, 'h00, 0, 0, 0));
    send(mk(OP_PUT_HEX, 'hFF, 0, 0, 0));
    send(mk(OP_PUT_HEX, 'hA5, 0, 0, 0));
    send(mk(OP_READ_CELL, 0, 0, 0, SCREEN_COLUMNS));
    send(mk(OP_READ_CELL, 0, 0, 0, SCREEN_COLUMNS + 1));
    send(mk(OP_MOUSE, 0, 127, 127, 0));
    send(mk(OP_READ_CELL, 0, 0, 0, CELL_COUNT - 1));
    send(mk(OP_MOUSE, 0, -128, -128, 0));
    send(mk(OP_READ_CELL, 0, 0, 0, 0));
    send(mk(OP_MOUSE, 0, 0, 0, 0));
    send(mk(OP_MOUSE, 0, 5, -3, 0));
    send(mk(OP_MOUSE, 0, 40, 12, 0));
    send(mk(OP_READ_CELL, 0, 0, 0, CELL_COUNT));
    send(mk(OP_READ_CELL, 0, 0, 0, 2047));
    send(mk(OP_READ_CELL, 0, 0, 0, MOUSE_HOME_IDX));

    // first run blanks between the two digits, the second on the last digit
    run_to_bottom(SCREEN_COLUMNS - 1);
    run_to_bottom(SCREEN_COLUMNS - 2);

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 149) == 0)
        run_to_bottom($urandom_range(SCREEN_COLUMNS - 10, SCREEN_COLUMNS - 1));
      else
        send(random_cmd());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("ran %0d commands: %0d put char, %0d put hex, %0d mouse moves, %0d cell reads",
             sent, op_count[OP_PUT_CHAR], op_count[OP_PUT_HEX], op_count[OP_MOUSE],
             op_count[OP_READ_CELL]);
    $display("%0d commands blanked the screen, %0d field errors", clears, fail_count);
    if (fail_count == 0)
      $display("PASS text_mode_console_writer");
    else
      $display("FAIL text_mode_console_writer");
    $finish;
  end

endmodule
